// ----- design/mmsl_pkg.sv -----
// Shared constants and types for the mecanum mixer with slew limit.
package mmsl_pkg;

  localparam int unsigned MOUSE_DIV_SHIFT_DEF = 4;

  localparam int unsigned STICK_W = 11;
  localparam int unsigned MIX_W   = 13;
  localparam int unsigned GAIN_W  = 4;
  localparam int unsigned STEP_W  = 12;
  localparam int unsigned WHEEL_W = 16;
  localparam int unsigned CAM_W   = 12;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned NUM_WHEELS = 4;

  localparam logic [1:0] ACT_KEYBOARD = 2'd1;
  localparam logic [1:0] ACT_REMOTE   = 2'd2;

  localparam logic [1:0] CFG_KEYBOARD_GAIN = 2'd0;
  localparam logic [1:0] CFG_RC_GAIN       = 2'd1;
  localparam logic [1:0] CFG_RAMP_STEP     = 2'd2;
  localparam logic [1:0] CFG_CAM_CENTER    = 2'd3;

  localparam logic [GAIN_W-1:0] KEYBOARD_GAIN_RST = 4'd10;
  localparam logic [GAIN_W-1:0] RC_GAIN_RST       = 4'd11;
  localparam logic [STEP_W-1:0] RAMP_STEP_RST     = 12'd50;
  localparam logic [CAM_W-1:0]  CAM_CENTER_RST    = 12'd1500;

  typedef struct packed {
    logic              advance;
    logic [1:0]        action;
    logic [GAIN_W-1:0] kb_gain;
    logic [GAIN_W-1:0] rc_gain;
    logic [STEP_W-1:0] ramp_step;
  } mmsl_ctrl_t;

endpackage

// ----- design/mmsl_wheel.sv -----
// One wheel: target mixing, gain, saturation and slew limit.
module mmsl_wheel import mmsl_pkg::*; #(
  parameter int unsigned MOUSE_DIV_SHIFT = MOUSE_DIV_SHIFT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mmsl_ctrl_t                ctrl_i,
  input  logic signed [MIX_W-1:0]   kb_base_i,
  input  logic signed [STICK_W-1:0] yaw_i,
  input  logic signed [MIX_W-1:0]   rc_sum_i,
  output logic signed [WHEEL_W-1:0] wheel_o
);

  localparam int unsigned NUM_W  = MIX_W + MOUSE_DIV_SHIFT + 1;
  localparam int unsigned KPROD_W = NUM_W + GAIN_W + 1;
  localparam int unsigned RPROD_W = MIX_W + GAIN_W + 1;
  localparam int unsigned RAMP_W  = WHEEL_W + 2;

  localparam logic signed [NUM_W-1:0]   BIAS  = NUM_W'((1 << MOUSE_DIV_SHIFT) - 1);
  localparam logic signed [KPROD_W-1:0] K_MAX = KPROD_W'(32767);
  localparam logic signed [KPROD_W-1:0] K_MIN = -KPROD_W'(32768);
  localparam logic signed [RPROD_W-1:0] R_MAX = RPROD_W'(32767);
  localparam logic signed [RPROD_W-1:0] R_MIN = -RPROD_W'(32768);

  logic signed [NUM_W-1:0]   num;
  logic signed [NUM_W-1:0]   bias;
  logic signed [NUM_W-1:0]   quot;
  logic signed [KPROD_W-1:0] kb_prod;
  logic signed [RPROD_W-1:0] rc_prod;
  logic signed [WHEEL_W-1:0] kb_tgt;
  logic signed [WHEEL_W-1:0] rc_tgt;
  logic signed [WHEEL_W-1:0] target_d, target_q;
  logic signed [RAMP_W-1:0]  up;
  logic signed [RAMP_W-1:0]  dn;
  logic signed [RAMP_W-1:0]  tgt_ext;
  logic signed [WHEEL_W-1:0] wheel_d, wheel_q;

  // truncate toward zero
  always_comb begin
    num     = (NUM_W'(kb_base_i) <<< MOUSE_DIV_SHIFT) + NUM_W'(yaw_i);
    bias    = num[NUM_W-1] ? BIAS : '0;
    quot    = (num + bias) >>> MOUSE_DIV_SHIFT;
    kb_prod = KPROD_W'(quot) * KPROD_W'($signed({1'b0, ctrl_i.kb_gain}));
    rc_prod = RPROD_W'(rc_sum_i) * RPROD_W'($signed({1'b0, ctrl_i.rc_gain}));
  end

  always_comb begin
    if (kb_prod > K_MAX) begin
      kb_tgt = 16'sh7fff;
    end else if (kb_prod < K_MIN) begin
      kb_tgt = 16'sh8000;
    end else begin
      kb_tgt = kb_prod[WHEEL_W-1:0];
    end
    if (rc_prod > R_MAX) begin
      rc_tgt = 16'sh7fff;
    end else if (rc_prod < R_MIN) begin
      rc_tgt = 16'sh8000;
    end else begin
      rc_tgt = rc_prod[WHEEL_W-1:0];
    end
  end

  always_comb begin
    case (ctrl_i.action)
      ACT_KEYBOARD: target_d = kb_tgt;
      ACT_REMOTE:   target_d = rc_tgt;
      default:      target_d = target_q;
    endcase
  end

  always_comb begin
    tgt_ext = RAMP_W'(target_d);
    up      = RAMP_W'(wheel_q) + RAMP_W'($signed({1'b0, ctrl_i.ramp_step}));
    dn      = RAMP_W'(wheel_q) - RAMP_W'($signed({1'b0, ctrl_i.ramp_step}));
    if (wheel_q < target_d) begin
      wheel_d = (up > tgt_ext) ? target_d : up[WHEEL_W-1:0];
    end else if (wheel_q > target_d) begin
      wheel_d = (dn < tgt_ext) ? target_d : dn[WHEEL_W-1:0];
    end else begin
      wheel_d = wheel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      wheel_q  <= '0;
    end else if (ctrl_i.advance) begin
      target_q <= target_d;
      wheel_q  <= wheel_d;
    end
  end

  assign wheel_o = wheel_q;

endmodule

// ----- design/mecanum_mix_with_slew_limit.sv -----
// Top level: input register, four wheel mixers with slew limit, camera duty.
// One beat in, one beat out per item. A new item is taken every cycle while the output is
// not stalled by out_ready_i; a result passes the input register, then the wheel and camera
// state registers, which are the result register. The throughput is set by the state
// update of each wheel's target and output. Registers may be written only while
// the block is idle; the configuration channel is always ready.
module mecanum_mix_with_slew_limit import mmsl_pkg::*; #(
  parameter int unsigned MOUSE_DIV_SHIFT = MOUSE_DIV_SHIFT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [STICK_W-1:0] yaw_stick_i,
  input  logic signed [STICK_W-1:0] cam_stick_i,
  input  logic signed [STICK_W-1:0] strafe_stick_i,
  input  logic signed [STICK_W-1:0] drive_stick_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [WHEEL_W-1:0] wheel_front_left_o,
  output logic signed [WHEEL_W-1:0] wheel_front_right_o,
  output logic signed [WHEEL_W-1:0] wheel_rear_left_o,
  output logic signed [WHEEL_W-1:0] wheel_rear_right_o,
  output logic [CAM_W-1:0]          cam_pulse_o
);

  localparam int unsigned CSUM_W = CAM_W + 2;

  logic [GAIN_W-1:0] kb_gain_q;
  logic [GAIN_W-1:0] rc_gain_q;
  logic [STEP_W-1:0] ramp_step_q;
  logic [CAM_W-1:0]  cam_center_q;

  logic                      s1_valid_q;
  logic [1:0]                action_q;
  logic signed [STICK_W-1:0] yaw_q;
  logic signed [STICK_W-1:0] cam_q;
  logic signed [STICK_W-1:0] strafe_q;
  logic signed [STICK_W-1:0] drive_q;
  logic                      out_valid_q;
  logic                      advance;
  logic                      in_fire;

  logic signed [MIX_W-1:0]   kb_base [NUM_WHEELS];
  logic signed [MIX_W-1:0]   rc_sum  [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] wheel   [NUM_WHEELS];
  mmsl_ctrl_t                ctrl;

  logic signed [CSUM_W-1:0] cam_sum;
  logic [CAM_W-1:0]         cam_d, cam_hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_gain_q    <= KEYBOARD_GAIN_RST;
      rc_gain_q    <= RC_GAIN_RST;
      ramp_step_q  <= RAMP_STEP_RST;
      cam_center_q <= CAM_CENTER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEYBOARD_GAIN: kb_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_RC_GAIN:       rc_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_RAMP_STEP:     ramp_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_CAM_CENTER:    cam_center_q <= cfg_data_i[CAM_W-1:0];
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= action_i;
      yaw_q    <= yaw_stick_i;
      cam_q    <= cam_stick_i;
      strafe_q <= strafe_stick_i;
      drive_q  <= drive_stick_i;
    end
  end

  always_comb begin
    kb_base[0] = -MIX_W'(strafe_q) + MIX_W'(drive_q);
    kb_base[1] = -MIX_W'(strafe_q) - MIX_W'(drive_q);
    kb_base[2] =  MIX_W'(strafe_q) + MIX_W'(drive_q);
    kb_base[3] =  MIX_W'(strafe_q) - MIX_W'(drive_q);
    rc_sum[0]  =  MIX_W'(strafe_q) + MIX_W'(drive_q) + MIX_W'(yaw_q);
    rc_sum[1]  =  MIX_W'(strafe_q) - MIX_W'(drive_q) + MIX_W'(yaw_q);
    rc_sum[2]  = -MIX_W'(strafe_q) + MIX_W'(drive_q) + MIX_W'(yaw_q);
    rc_sum[3]  = -MIX_W'(strafe_q) - MIX_W'(drive_q) + MIX_W'(yaw_q);
  end

  always_comb begin
    ctrl.advance   = advance;
    ctrl.action    = action_q;
    ctrl.kb_gain   = kb_gain_q;
    ctrl.rc_gain   = rc_gain_q;
    ctrl.ramp_step = ramp_step_q;
  end

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
    mmsl_wheel #(
      .MOUSE_DIV_SHIFT(MOUSE_DIV_SHIFT)
    ) u_wheel (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .kb_base_i(kb_base[w]),
      .yaw_i    (yaw_q),
      .rc_sum_i (rc_sum[w]),
      .wheel_o  (wheel[w])
    );
  end

  always_comb begin
    case (action_q)
      ACT_KEYBOARD: cam_sum = CSUM_W'($signed({2'b00, cam_center_q})) - CSUM_W'(cam_q);
      default:      cam_sum = CSUM_W'($signed({2'b00, cam_center_q})) + CSUM_W'(cam_q);
    endcase
    if (action_q != ACT_KEYBOARD && action_q != ACT_REMOTE) begin
      cam_d = cam_hold_q;
    end else if (cam_sum < 0) begin
      cam_d = '0;
    end else if (cam_sum > CSUM_W'(4095)) begin
      cam_d = '1;
    end else begin
      cam_d = cam_sum[CAM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_hold_q <= CAM_CENTER_RST;
    end else if (advance) begin
      cam_hold_q <= cam_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign wheel_front_left_o  = wheel[0];
  assign wheel_front_right_o = wheel[1];
  assign wheel_rear_left_o   = wheel[2];
  assign wheel_rear_right_o  = wheel[3];
  assign cam_pulse_o         = cam_hold_q;

endmodule
